/* hdl/lattice_boltzmann_d2q9_collision_core_defines.svh */
// assertion macros for the d2q9 collision core checker
`ifndef LATTICE_BOLTZMANN_D2Q9_COLLISION_CORE_DEFINES_SVH
`define LATTICE_BOLTZMANN_D2Q9_COLLISION_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define LBMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbmc check failed: lbl");

// next-cycle implication, off during reset
`define LBMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbmc check failed: lbl");

// condition in the cycle after reset
`define LBMC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("lbmc check failed: lbl");

`endif

/* hdl/lbmc_pkg.sv */
// ----------------------------------------------------------------------------
// lbmc_pkg
// types, constants and fixed point helpers for the d2q9 collision core
// ----------------------------------------------------------------------------
package lbmc_pkg;

  localparam int DIRS       = 9;
  localparam int QSHIFT     = 28;
  localparam int DIV_STAGES = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CS2    = 2'd1;

  localparam logic [29:0] RELAX_RATE_RST = 30'd268435456;
  localparam logic [30:0] INV_CS2_RST    = 31'd805306368;

  localparam logic signed [31:0] W_REST = 32'sd119304647;
  localparam logic signed [31:0] W_AXIS = 32'sd29826162;
  localparam logic signed [31:0] W_DIAG = 32'sd7456540;
  localparam logic signed [63:0] Q_ONE  = 64'sd268435456;
  localparam logic signed [63:0] Q_HALF = 64'sd134217728;

  typedef struct packed {
    logic signed [31:0] dist_rest;
    logic signed [31:0] dist_east;
    logic signed [31:0] dist_north;
    logic signed [31:0] dist_west;
    logic signed [31:0] dist_south;
    logic signed [31:0] dist_northeast;
    logic signed [31:0] dist_northwest;
    logic signed [31:0] dist_southwest;
    logic signed [31:0] dist_southeast;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_rest;
    logic signed [31:0] new_east;
    logic signed [31:0] new_north;
    logic signed [31:0] new_west;
    logic signed [31:0] new_south;
    logic signed [31:0] new_northeast;
    logic signed [31:0] new_northwest;
    logic signed [31:0] new_southwest;
    logic signed [31:0] new_southeast;
    logic signed [31:0] density;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
  } out_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    return (p + Q_HALF) >>> QSHIFT;
  endfunction

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = a;
    bx = b;
    return sat32(rnd(ax * bx));
  endfunction

  function automatic logic signed [31:0] weight(input logic [3:0] i);
    case (i)
      4'd0: return W_REST;
      4'd1, 4'd2, 4'd3, 4'd4: return W_AXIS;
      default: return W_DIAG;
    endcase
  endfunction

endpackage

/* hdl/lbmc_div.sv */
// ----------------------------------------------------------------------------
// lbmc_div
// pipelined restoring divider, one quotient bit per stage, saturated result
// ----------------------------------------------------------------------------
module lbmc_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [33:0]              num_mag,
  input  logic [30:0]              den,
  input  lbmc_pkg::div_ctl_t       ctl_in,
  output logic signed [31:0]       quot
);
  import lbmc_pkg::*;

  logic [30:0] rem   [DIV_STAGES];
  logic [31:0] low   [DIV_STAGES];
  logic [31:0] qb    [DIV_STAGES];
  logic [30:0] dv    [DIV_STAGES];
  div_ctl_t    ct    [DIV_STAGES];

  logic [30:0] r_in  [DIV_STAGES];
  logic [31:0] l_in  [DIV_STAGES];
  logic [31:0] q_in  [DIV_STAGES];
  logic [30:0] d_in  [DIV_STAGES];
  div_ctl_t    c_in  [DIV_STAGES];
  logic [31:0] t     [DIV_STAGES];
  logic [30:0] rem_next [DIV_STAGES];
  logic [31:0] qb_next  [DIV_STAGES];

  genvar g;
  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
        assign r_in[g] = {1'b0, num_mag[33:4]};
        assign l_in[g] = {num_mag[3:0], 28'd0};
        assign q_in[g] = 32'd0;
        assign d_in[g] = den;
        assign c_in[g] = ctl_in;
      end else begin : g_rest
        assign r_in[g] = rem[g-1];
        assign l_in[g] = low[g-1];
        assign q_in[g] = qb[g-1];
        assign d_in[g] = dv[g-1];
        assign c_in[g] = ct[g-1];
      end

      always_comb begin
        t[g] = {r_in[g], l_in[g][31]};
        if (t[g] >= {1'b0, d_in[g]}) begin
          rem_next[g] = 31'(t[g] - {1'b0, d_in[g]});
          qb_next[g]  = {q_in[g][30:0], 1'b1};
        end else begin
          rem_next[g] = t[g][30:0];
          qb_next[g]  = {q_in[g][30:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[g] <= rem_next[g];
          low[g] <= {l_in[g][30:0], 1'b0};
          qb[g]  <= qb_next[g];
          dv[g]  <= d_in[g];
          ct[g]  <= c_in[g];
        end
      end
    end
  endgenerate

  logic [31:0] q_u;
  div_ctl_t    q_c;
  assign q_u = qb[DIV_STAGES-1];
  assign q_c = ct[DIV_STAGES-1];

  always_comb begin
    if (q_c.neg) begin
      if (q_c.ovf || q_u > 32'h80000000) begin
        quot = 32'sh80000000;
      end else begin
        quot = $signed(32'd0 - q_u);
      end
    end else begin
      if (q_c.ovf || q_u[31]) begin
        quot = 32'sh7fffffff;
      end else begin
        quot = $signed(q_u);
      end
    end
  end

endmodule

/* hdl/lattice_boltzmann_d2q9_collision_core.sv */
// ----------------------------------------------------------------------------
// lattice_boltzmann_d2q9_collision_core
// d2q9 bgk collision of one lattice cell per transaction, q4.28 fixed point
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready/in_data carries the nine distributions of
//   one cell; output channel out_valid/out_ready/out_data carries the nine
//   relaxed distributions plus density and velocity.
//   cfg_we/cfg_index/cfg_data write relax_rate (index 0) and
//   inv_sound_speed_sq (index 1); other indexes are ignored. write only idle.
// pipeline: 41 register stages (input stage, 32-stage velocity divider and
//   eight arithmetic stages).
// throughput: one cell per cycle when not stalled; all stages are registers.
// stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is dropped or repeated.
// reset: clears all valid bits and loads the register defaults
//   (relax rate 1.0, inverse sound speed squared 3.0).
// ----------------------------------------------------------------------------
module lattice_boltzmann_d2q9_collision_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lbmc_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lbmc_pkg::out_t       out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [30:0]          cfg_data
);
  import lbmc_pkg::*;

  logic [29:0] relax_rate;
  logic [30:0] inv_cs2;
  logic signed [31:0] k_s;
  logic signed [31:0] rate_s;
  logic en;

  assign k_s    = $signed({1'b0, inv_cs2});
  assign rate_s = $signed({2'b0, relax_rate});
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= RELAX_RATE_RST;
      inv_cs2    <= INV_CS2_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RELAX_RATE) begin
        relax_rate <= cfg_data[29:0];
      end else if (cfg_index == CFG_INV_CS2) begin
        inv_cs2 <= cfg_data;
      end
    end
  end

  // moments
  logic signed [31:0] fi [DIRS];
  logic signed [35:0] sum_c, mx_c, my_c;
  assign fi[0] = in_data.dist_rest;
  assign fi[1] = in_data.dist_east;
  assign fi[2] = in_data.dist_north;
  assign fi[3] = in_data.dist_west;
  assign fi[4] = in_data.dist_south;
  assign fi[5] = in_data.dist_northeast;
  assign fi[6] = in_data.dist_northwest;
  assign fi[7] = in_data.dist_southwest;
  assign fi[8] = in_data.dist_southeast;

  always_comb begin
    sum_c = 36'sd0;
    for (int i = 0; i < DIRS; i++) begin
      sum_c = sum_c + 36'(fi[i]);
    end
    mx_c = 36'(fi[1]) - 36'(fi[3]) + 36'(fi[5]) - 36'(fi[6])
         - 36'(fi[7]) + 36'(fi[8]);
    my_c = 36'(fi[2]) - 36'(fi[4]) + 36'(fi[5]) + 36'(fi[6])
         - 36'(fi[7]) - 36'(fi[8]);
  end

  logic               p1_v;
  logic signed [31:0] p1_f [DIRS];
  logic signed [35:0] p1_sum, p1_mx, p1_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_f   <= fi;
      p1_sum <= sum_c;
      p1_mx  <= mx_c;
      p1_my  <= my_c;
    end
  end

  // divider setup
  logic signed [31:0] rho_c;
  logic               pos_c;
  logic [35:0]        mxa, mya;
  div_ctl_t           ctl_x, ctl_y;
  logic signed [31:0] qx, qy;

  always_comb begin
    rho_c = sat32(64'(p1_sum));
    pos_c = rho_c > 32'sd0;
    mxa = p1_mx[35] ? 36'(-p1_mx) : 36'(p1_mx);
    mya = p1_my[35] ? 36'(-p1_my) : 36'(p1_my);
    ctl_x.neg = p1_mx[35];
    ctl_y.neg = p1_my[35];
    ctl_x.ovf = mxa[34:0] >= {rho_c[30:0], 4'd0};
    ctl_y.ovf = mya[34:0] >= {rho_c[30:0], 4'd0};
  end

  lbmc_div u_div_x (
    .clk     (clk),
    .en      (en),
    .num_mag (mxa[33:0]),
    .den     (rho_c[30:0]),
    .ctl_in  (ctl_x),
    .quot    (qx)
  );

  lbmc_div u_div_y (
    .clk     (clk),
    .en      (en),
    .num_mag (mya[33:0]),
    .den     (rho_c[30:0]),
    .ctl_in  (ctl_y),
    .quot    (qy)
  );

  // side line aligned with the divider
  logic               ps_v   [DIV_STAGES];
  logic signed [31:0] ps_f   [DIV_STAGES][DIRS];
  logic signed [31:0] ps_rho [DIV_STAGES];
  logic               ps_pos [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        ps_v[s] <= 1'b0;
      end
    end else if (en) begin
      ps_v[0] <= p1_v;
      for (int s = 1; s < DIV_STAGES; s++) begin
        ps_v[s] <= ps_v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_f[0]   <= p1_f;
      ps_rho[0] <= rho_c;
      ps_pos[0] <= pos_c;
      for (int s = 1; s < DIV_STAGES; s++) begin
        ps_f[s]   <= ps_f[s-1];
        ps_rho[s] <= ps_rho[s-1];
        ps_pos[s] <= ps_pos[s-1];
      end
    end
  end

  // arithmetic stages
  logic               p2_v, p3_v, p4_v, p5_v, p6_v, p7_v, p8_v, p9_v;
  logic signed [31:0] p2_f [DIRS], p3_f [DIRS], p4_f [DIRS], p5_f [DIRS];
  logic signed [31:0] p6_f [DIRS], p7_f [DIRS], p8_f [DIRS];
  logic signed [31:0] p2_rho, p3_rho, p4_rho, p5_rho, p6_rho, p7_rho, p8_rho, p9_rho;
  logic signed [31:0] p2_ux, p3_ux, p4_ux, p5_ux, p6_ux, p7_ux, p8_ux, p9_ux;
  logic signed [31:0] p2_uy, p3_uy, p4_uy, p5_uy, p6_uy, p7_uy, p8_uy, p9_uy;
  logic signed [31:0] p3_sqx, p3_sqy, p4_usq, p5_hp;
  logic signed [31:0] p3_cu [DIRS], p4_a [DIRS], p5_a [DIRS], p5_a2 [DIRS];
  logic signed [31:0] p3_rw [DIRS], p4_rw [DIRS], p5_rw [DIRS], p6_rw [DIRS];
  logic signed [31:0] p6_poly [DIRS], p7_feq [DIRS], p9_nv [DIRS];
  logic signed [39:0] p8_prod [DIRS];
  logic signed [31:0] cu_c [DIRS];
  logic signed [63:0] uxx, uyy, h_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
      p6_v <= 1'b0;
      p7_v <= 1'b0;
      p8_v <= 1'b0;
      p9_v <= 1'b0;
    end else if (en) begin
      p2_v <= ps_v[DIV_STAGES-1];
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
      p6_v <= p5_v;
      p7_v <= p6_v;
      p8_v <= p7_v;
      p9_v <= p8_v;
    end
  end

  always_comb begin
    uxx = 64'(p2_ux);
    uyy = 64'(p2_uy);
    cu_c[0] = 32'sd0;
    cu_c[1] = p2_ux;
    cu_c[2] = p2_uy;
    cu_c[3] = sat32(-uxx);
    cu_c[4] = sat32(-uyy);
    cu_c[5] = sat32(uxx + uyy);
    cu_c[6] = sat32(uyy - uxx);
    cu_c[7] = sat32(-uxx - uyy);
    cu_c[8] = sat32(uxx - uyy);
    h_c = 64'(p5_hp) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // velocity
      p2_f   <= ps_f[DIV_STAGES-1];
      p2_rho <= ps_rho[DIV_STAGES-1];
      p2_ux  <= ps_pos[DIV_STAGES-1] ? qx : 32'sd0;
      p2_uy  <= ps_pos[DIV_STAGES-1] ? qy : 32'sd0;
      // squares, projections, weighted density
      p3_f   <= p2_f;
      p3_rho <= p2_rho;
      p3_ux  <= p2_ux;
      p3_uy  <= p2_uy;
      p3_sqx <= mulq(p2_ux, p2_ux);
      p3_sqy <= mulq(p2_uy, p2_uy);
      p3_cu  <= cu_c;
      for (int i = 0; i < DIRS; i++) begin
        p3_rw[i] <= mulq(p2_rho, weight(4'(i)));
      end
      // speed squared, scaled projections
      p4_f   <= p3_f;
      p4_rho <= p3_rho;
      p4_ux  <= p3_ux;
      p4_uy  <= p3_uy;
      p4_rw  <= p3_rw;
      p4_usq <= sat32(64'(p3_sqx) + 64'(p3_sqy));
      for (int i = 0; i < DIRS; i++) begin
        p4_a[i] <= mulq(p3_cu[i], k_s);
      end
      // second order terms
      p5_f   <= p4_f;
      p5_rho <= p4_rho;
      p5_ux  <= p4_ux;
      p5_uy  <= p4_uy;
      p5_rw  <= p4_rw;
      p5_a   <= p4_a;
      p5_hp  <= mulq(p4_usq, k_s);
      for (int i = 0; i < DIRS; i++) begin
        p5_a2[i] <= mulq(p4_a[i], p4_a[i]);
      end
      // bracket
      p6_f   <= p5_f;
      p6_rho <= p5_rho;
      p6_ux  <= p5_ux;
      p6_uy  <= p5_uy;
      p6_rw  <= p5_rw;
      for (int i = 0; i < DIRS; i++) begin
        p6_poly[i] <= sat32(Q_ONE + 64'(p5_a[i]) + (64'(p5_a2[i]) >>> 1) - h_c);
      end
      // equilibrium
      p7_f   <= p6_f;
      p7_rho <= p6_rho;
      p7_ux  <= p6_ux;
      p7_uy  <= p6_uy;
      for (int i = 0; i < DIRS; i++) begin
        p7_feq[i] <= mulq(p6_rw[i], p6_poly[i]);
      end
      // relaxation product
      p8_f   <= p7_f;
      p8_rho <= p7_rho;
      p8_ux  <= p7_ux;
      p8_uy  <= p7_uy;
      for (int i = 0; i < DIRS; i++) begin
        p8_prod[i] <= 40'(rnd((64'(p7_f[i]) - 64'(p7_feq[i])) * 64'(rate_s)));
      end
      // final subtraction
      p9_rho <= p8_rho;
      p9_ux  <= p8_ux;
      p9_uy  <= p8_uy;
      for (int i = 0; i < DIRS; i++) begin
        p9_nv[i] <= sat32(64'(p8_f[i]) - 64'(p8_prod[i]));
      end
    end
  end

  assign out_valid = p9_v;

  always_comb begin
    out_data.new_rest      = p9_nv[0];
    out_data.new_east      = p9_nv[1];
    out_data.new_north     = p9_nv[2];
    out_data.new_west      = p9_nv[3];
    out_data.new_south     = p9_nv[4];
    out_data.new_northeast = p9_nv[5];
    out_data.new_northwest = p9_nv[6];
    out_data.new_southwest = p9_nv[7];
    out_data.new_southeast = p9_nv[8];
    out_data.density       = p9_rho;
    out_data.velocity_x    = p9_ux;
    out_data.velocity_y    = p9_uy;
  end

endmodule

/* hdl/lbmc_checker.sv */
// ----------------------------------------------------------------------------
// lbmc_checker
// port-level checks for the d2q9 collision core, bound to the top level
// ----------------------------------------------------------------------------
`include "lattice_boltzmann_d2q9_collision_core_defines.svh"

module lbmc_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input lbmc_pkg::out_t out_data,
  input logic           out_valid,
  input logic           out_ready
);
  import lbmc_pkg::*;

  `LBMC_ASSERT_RST(a_reset_empty, !out_valid)
  `LBMC_ASSERT_IMP(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready))
  `LBMC_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `LBMC_ASSERT_IMP(a_zero_vel, out_valid && out_data.density <= 32'sd0, out_data.velocity_x == 32'sd0 && out_data.velocity_y == 32'sd0)

endmodule

bind lattice_boltzmann_d2q9_collision_core lbmc_checker u_lbmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the d2q9 collision core cell by cell against an independent fixed
// point prediction, with random idling on both channels and register changes
// between phases
// ----------------------------------------------------------------------------
module testbench;
  import lbmc_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;
  logic in_accepted = 1'b0;

  lattice_boltzmann_d2q9_collision_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  in_t pending_cells[$];
  out_t expected_cells[$];
  logic [29:0] model_rate;
  logic [30:0] model_k;
  int mismatches;
  int cells_sent;
  int cells_checked;
  int cfg_writes;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_prod(input longint a, input longint b);
    return (a * b + 64'sd134217728) >>> 28;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return sat_q(round_prod(a, b));
  endfunction

  function automatic out_t collide_cell(input in_t c);
    longint f[9];
    longint wt[9];
    int cx[9];
    int cy[9];
    longint sum, mx, my, rho, ux, uy, usq, h, cu, a, poly, feq, nv;
    out_t r;
    logic [9*32-1:0] flat;
    logic [12*32-1:0] res;
    flat = c;
    cx = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    cy = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    wt = '{119304647, 29826162, 29826162, 29826162, 29826162,
           7456540, 7456540, 7456540, 7456540};
    sum = 0; mx = 0; my = 0; ux = 0; uy = 0;
    for (int i = 0; i < 9; i++) begin
      f[i] = longint'($signed(flat[(8-i)*32 +: 32]));
      sum += f[i];
      mx += f[i] * cx[i];
      my += f[i] * cy[i];
    end
    rho = sat_q(sum);
    if (rho > 0) begin
      ux = sat_q((mx * 64'sd268435456) / rho);
      uy = sat_q((my * 64'sd268435456) / rho);
    end
    usq = sat_q(qmul(ux, ux) + qmul(uy, uy));
    h = qmul(usq, longint'(model_k)) >>> 1;
    for (int i = 0; i < 9; i++) begin
      cu = sat_q(ux * cx[i] + uy * cy[i]);
      a = qmul(cu, longint'(model_k));
      poly = sat_q(64'sd268435456 + a + (qmul(a, a) >>> 1) - h);
      feq = qmul(qmul(rho, wt[i]), poly);
      nv = sat_q(f[i] - round_prod(f[i] - feq, longint'(model_rate)));
      res[(11-i)*32 +: 32] = nv[31:0];
    end
    res[2*32 +: 32] = rho[31:0];
    res[32 +: 32] = ux[31:0];
    res[31:0] = uy[31:0];
    r = res;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_accepted) begin
        if (pending_cells.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
          in_data <= pending_cells.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || $urandom_range(99) >= 12;
    end
  end

  // input transaction seen at the last rising edge
  always @(posedge clk) begin
    in_accepted <= in_valid && in_ready;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_cells.push_back(collide_cell(in_data));
        cells_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", out_data);
        end else begin
          out_t e;
          e = expected_cells.pop_front();
          cells_checked++;
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch rest %h/%h east %h/%h north %h/%h west %h/%h",
                       e.new_rest, out_data.new_rest, e.new_east, out_data.new_east,
                       e.new_north, out_data.new_north, e.new_west, out_data.new_west);
              $display("  south %h/%h ne %h/%h nw %h/%h sw %h/%h se %h/%h",
                       e.new_south, out_data.new_south, e.new_northeast,
                       out_data.new_northeast, e.new_northwest, out_data.new_northwest,
                       e.new_southwest, out_data.new_southwest, e.new_southeast,
                       out_data.new_southeast);
              $display("  density %h/%h vx %h/%h vy %h/%h", e.density, out_data.density,
                       e.velocity_x, out_data.velocity_x, e.velocity_y,
                       out_data.velocity_y);
            end
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RELAX_RATE) model_rate = val[29:0];
    else if (idx == CFG_INV_CS2) model_k = val;
    cfg_writes++;
  endtask

  task automatic drain;
    while (pending_cells.size() > 0 || expected_cells.size() > 0 || in_valid)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_dist(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'sd29826162 + $signed($urandom_range(0, 8000000)) - 32'sd4000000;
      default: return $signed($urandom_range(0, 60000000)) - 32'sd10000000;
    endcase
  endfunction

  task automatic queue_random(input int n);
    in_t c;
    logic [9*32-1:0] flat;
    int mode;
    for (int j = 0; j < n; j++) begin
      mode = $urandom_range(9);
      mode = (mode < 2) ? 0 : (mode < 6 ? 1 : 2);
      for (int i = 0; i < 9; i++) flat[i*32 +: 32] = rand_dist(mode);
      c = flat;
      pending_cells.push_back(c);
    end
  endtask

  task automatic queue_fill(input logic signed [31:0] v);
    in_t c;
    c = {9{v}};
    pending_cells.push_back(c);
  endtask

  initial begin
    in_t c;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RELAX_RATE;
    cfg_data = '0;
    calm = 1'b0;
    mismatches = 0;
    cells_sent = 0;
    cells_checked = 0;
    cfg_writes = 0;
    model_rate = RELAX_RATE_RST;
    model_k = INV_CS2_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cells at reset settings
    queue_fill(32'sh00000000);
    queue_fill(32'sh7fffffff);
    queue_fill(32'sh80000000);
    queue_fill(32'shffffffff);
    queue_fill(32'sh02000000);
    queue_fill(-32'sh02000000);
    c = '0; c.dist_east = 32'sh10000000; pending_cells.push_back(c);
    c = '0; c.dist_north = 32'sh10000000; c.dist_rest = 32'sh01000000;
    pending_cells.push_back(c);
    c = '0; c.dist_west = 32'sh10000000; c.dist_southwest = 32'sh08000000;
    pending_cells.push_back(c);
    c = {9{32'sh01000000}}; c.dist_east = 32'sh7fffffff; c.dist_west = 32'sh80000000;
    pending_cells.push_back(c);
    c = {9{32'sh00000001}}; c.dist_northeast = 32'sh40000000;
    pending_cells.push_back(c);
    c = {9{32'sh10000000}}; c.dist_south = -32'sh70000000; pending_cells.push_back(c);
    queue_random(8);
    drain();

    write_reg(CFG_RELAX_RATE, 31'd536870912);
    write_reg(CFG_INV_CS2, 31'd268435456);
    write_reg(CFG_UNUSED, 31'h7fffffff);
    queue_fill(32'sh7fffffff);
    queue_fill(32'sh80000000);
    queue_random(300);
    drain();

    write_reg(CFG_RELAX_RATE, 31'd0);
    write_reg(CFG_INV_CS2, 31'd1073741824);
    calm = 1'b1;
    queue_random(250);
    drain();
    calm = 1'b0;

    write_reg(CFG_RELAX_RATE, 31'h3fffffff);
    write_reg(CFG_INV_CS2, 31'h7fffffff);
    queue_random(150);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_RELAX_RATE, 31'($urandom_range(0, 536870912)));
      write_reg(CFG_INV_CS2, 31'($urandom_range(268435456, 1073741824)));
      queue_random(160);
      drain();
    end

    $display("%0d cells checked over %0d register writes, extreme and random settings",
             cells_checked, cfg_writes);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/lbmc_pkg.sv
hdl/lbmc_div.sv
hdl/lattice_boltzmann_d2q9_collision_core.sv
hdl/lbmc_checker.sv
verif/testbench.sv
